>>> design/vdtp_pkg.sv
// Package: shared types and constants of the vendor descriptor TLV parser.
`timescale 1ns / 1ps

package vdtp_pkg;

    // Header layout
    localparam logic [7:0]  HDR_TAG   = 8'h5f;
    localparam logic [7:0]  HDR_VER   = 8'h01;
    localparam logic [7:0]  HDR_PAD   = 8'h00;
    localparam logic [7:0]  HDR_BYTES = 8'd5;
    localparam logic [7:0]  HDR_BIAS  = 8'd2;

    // Record key that carries the pixel-area limit
    localparam logic [15:0] KEY_LIMIT = 16'h0200;

    // Capture window length in bytes
    localparam logic [2:0]  CAP_BYTES = 3'd4;

    typedef enum logic [1:0] {
        STATUS_BUSY    = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_BAD_HDR = 2'd2,
        STATUS_OK      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_KEY_LO = 2'd0,
        PH_KEY_HI = 2'd1,
        PH_LEN    = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_flag;
        logic       last_flag;
    } in_item_t;

    typedef struct packed {
        logic        done_res;
        status_t     status;
        logic        limit_updated;
        logic [31:0] pixel_limit;
    } result_t;

endpackage

>>> design/vdtp_in_if.sv
// Interface: input byte channel with valid/ready handshake.
`timescale 1ns / 1ps

interface vdtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_flag;
    logic       last_flag;

    modport source (output valid, output data_byte, output first_flag, output last_flag,
                    input ready);
    modport sink   (input valid, input data_byte, input first_flag, input last_flag,
                    output ready);
endinterface

>>> design/vdtp_out_if.sv
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface vdtp_out_if;
    logic        valid;
    logic        ready;
    logic        done_res;
    logic [1:0]  status;
    logic        limit_updated;
    logic [31:0] pixel_limit;

    modport source (output valid, output done_res, output status, output limit_updated,
                    output pixel_limit, input ready);
    modport sink   (input valid, input done_res, input status, input limit_updated,
                    input pixel_limit, output ready);
endinterface

>>> design/vdtp_parser.sv
// Parser state: header check, record walk, limit capture and commit per byte.
`timescale 1ns / 1ps

module vdtp_parser #(
    parameter int MAX_DESC_BYTES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  vdtp_pkg::in_item_t item,
    output vdtp_pkg::result_t  result
);
    import vdtp_pkg::*;

    localparam int CNT_W = $clog2(MAX_DESC_BYTES + 1);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       header_first_reg, header_first_next;
    logic [7:0]       header_fifth_reg, header_fifth_next;
    logic             header_mid_ok_reg, header_mid_ok_next;
    phase_t           record_phase_reg, record_phase_next;
    logic [7:0]       key_low_byte_reg, key_low_byte_next;
    logic [7:0]       skip_left_reg, skip_left_next;
    logic [2:0]       cap_left_reg, cap_left_next;
    logic             cap_pend_reg, cap_pend_next;
    logic [31:0]      cap_value_reg, cap_value_next;
    logic             cand_seen_reg, cand_seen_next;
    logic [31:0]      stored_limit_reg, stored_limit_next;

    // State after this byte, before end-of-descriptor handling
    logic [CNT_W-1:0] cnt_s;
    logic [7:0]       hfirst_s, hfifth_s, klo_s, skip_s;
    logic             hmid_s, pend_s, cand_s;
    phase_t           phase_s;
    logic [2:0]       left_s;
    logic [31:0]      cval_s;

    logic [7:0]       len;
    status_t          status_c;
    logic             commit;

    // Next-state logic for one byte
    always_comb
    begin
        logic [7:0] b;
        b = item.data_byte;

        if (item.first_flag)
        begin
            cnt_s    = '0;
            hfirst_s = '0;
            hfifth_s = '0;
            hmid_s   = 1'b0;
            phase_s  = PH_KEY_LO;
            klo_s    = '0;
            skip_s   = '0;
            left_s   = '0;
            pend_s   = 1'b0;
            cval_s   = '0;
            cand_s   = 1'b0;
        end
        else
        begin
            cnt_s    = byte_count_reg;
            hfirst_s = header_first_reg;
            hfifth_s = header_fifth_reg;
            hmid_s   = header_mid_ok_reg;
            phase_s  = record_phase_reg;
            klo_s    = key_low_byte_reg;
            skip_s   = skip_left_reg;
            left_s   = cap_left_reg;
            pend_s   = cap_pend_reg;
            cval_s   = cap_value_reg;
            cand_s   = cand_seen_reg;
        end

        if (cnt_s < CNT_W'(MAX_DESC_BYTES))
        begin
            if (cnt_s == CNT_W'(0))
            begin
                hfirst_s = b;
                hmid_s   = 1'b1;
            end
            else if (cnt_s == CNT_W'(1))
            begin
                if (b != HDR_TAG) hmid_s = 1'b0;
            end
            else if (cnt_s == CNT_W'(2))
            begin
                if (b != HDR_VER) hmid_s = 1'b0;
            end
            else if (cnt_s == CNT_W'(3))
            begin
                if (b != HDR_PAD) hmid_s = 1'b0;
            end
            else if (cnt_s == CNT_W'(4))
            begin
                hfifth_s = b;
            end
            else
            begin
                // Capture sees the state before this byte's record step
                if (!pend_s)
                begin
                    case (left_s)
                        3'd4:    cval_s[7:0]   = cval_s[7:0]   | b;
                        3'd3:    cval_s[15:8]  = cval_s[15:8]  | b;
                        3'd2:    cval_s[23:16] = cval_s[23:16] | b;
                        3'd1:    cval_s[31:24] = cval_s[31:24] | b;
                        default: cval_s = cval_s;
                    endcase
                    if (left_s != 3'd0 && left_s <= CAP_BYTES)
                        left_s = left_s - 3'd1;
                end

                case (phase_s)
                    PH_KEY_LO:
                    begin
                        klo_s   = b;
                        phase_s = PH_KEY_HI;
                    end
                    PH_KEY_HI:
                    begin
                        if (klo_s == KEY_LIMIT[7:0] && b == KEY_LIMIT[15:8])
                        begin
                            cand_s = 1'b1;
                            cval_s = '0;
                            left_s = CAP_BYTES;
                            pend_s = 1'b1;
                        end
                        phase_s = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        pend_s  = 1'b0;
                        skip_s  = b;
                        phase_s = (b == 8'd0) ? PH_KEY_LO : PH_SKIP;
                    end
                    default:
                    begin
                        skip_s = skip_s - 8'd1;
                        if (skip_s == 8'd0)
                            phase_s = PH_KEY_LO;
                    end
                endcase
            end
            cnt_s = cnt_s + CNT_W'(1);
        end
    end

    // End-of-descriptor decision and register inputs
    always_comb
    begin
        len      = 8'(cnt_s);
        status_c = STATUS_BUSY;
        commit   = 1'b0;
        if (item.last_flag)
        begin
            if (len <= HDR_BYTES)
                status_c = STATUS_SHORT;
            else if (hfirst_s != len || !hmid_s || hfifth_s != len - HDR_BIAS)
                status_c = STATUS_BAD_HDR;
            else
            begin
                status_c = STATUS_OK;
                commit   = cand_s;
            end
        end

        stored_limit_next = commit ? cval_s : stored_limit_reg;

        if (item.last_flag)
        begin
            byte_count_next    = '0;
            header_first_next  = '0;
            header_fifth_next  = '0;
            header_mid_ok_next = 1'b0;
            record_phase_next  = PH_KEY_LO;
            key_low_byte_next  = '0;
            skip_left_next     = '0;
            cap_left_next      = '0;
            cap_pend_next      = 1'b0;
            cap_value_next     = '0;
            cand_seen_next     = 1'b0;
        end
        else
        begin
            byte_count_next    = cnt_s;
            header_first_next  = hfirst_s;
            header_fifth_next  = hfifth_s;
            header_mid_ok_next = hmid_s;
            record_phase_next  = phase_s;
            key_low_byte_next  = klo_s;
            skip_left_next     = skip_s;
            cap_left_next      = left_s;
            cap_pend_next      = pend_s;
            cap_value_next     = cval_s;
            cand_seen_next     = cand_s;
        end

        result.done_res      = item.last_flag;
        result.status        = status_c;
        result.limit_updated = commit;
        result.pixel_limit   = stored_limit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            header_first_reg  <= '0;
            header_fifth_reg  <= '0;
            header_mid_ok_reg <= 1'b0;
            record_phase_reg  <= PH_KEY_LO;
            key_low_byte_reg  <= '0;
            skip_left_reg     <= '0;
            cap_left_reg      <= '0;
            cap_pend_reg      <= 1'b0;
            cap_value_reg     <= '0;
            cand_seen_reg     <= 1'b0;
            stored_limit_reg  <= '0;
        end
        else if (take)
        begin
            byte_count_reg    <= byte_count_next;
            header_first_reg  <= header_first_next;
            header_fifth_reg  <= header_fifth_next;
            header_mid_ok_reg <= header_mid_ok_next;
            record_phase_reg  <= record_phase_next;
            key_low_byte_reg  <= key_low_byte_next;
            skip_left_reg     <= skip_left_next;
            cap_left_reg      <= cap_left_next;
            cap_pend_reg      <= cap_pend_next;
            cap_value_reg     <= cap_value_next;
            cand_seen_reg     <= cand_seen_next;
            stored_limit_reg  <= stored_limit_next;
        end
    end

endmodule

>>> design/vdtp_out_stage.sv
// Result register: holds one result until the sink takes the transfer.
`timescale 1ns / 1ps

module vdtp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  vdtp_pkg::result_t  result_in,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              can_load,
    output vdtp_pkg::result_t  result_out
);
    import vdtp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = res_reg;

endmodule

>>> design/vendor_descriptor_tlv_parser_core.sv
// Top level: vendor descriptor TLV parser core with byte input and result output channels.
`timescale 1ns / 1ps

// Takes one descriptor byte per transfer and returns one result per byte, registered
// and valid in the cycle after the byte is accepted. A new byte is accepted in every cycle
// as long as the result register is empty or being drained in the same cycle, so the
// sustained rate is one byte per clock; the only stall comes from the result
// sink holding ready low. The first five bytes form a header that is judged when
// the byte flagged last arrives; the remaining bytes are walked as key/length
// records, and key 0x0200 captures the four bytes after its length byte as the
// pixel-area limit. The limit is committed when such a key was seen and the header
// is valid and longer than five bytes; pixel_limit always shows the stored value after
// that byte. Bytes beyond MAX_DESC_BYTES are not counted or parsed; a first flag
// abandons any descriptor in progress.
module vendor_descriptor_tlv_parser_core #(
    parameter int MAX_DESC_BYTES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    vdtp_in_if.sink    in_ch,
    vdtp_out_if.source out_ch
);
    import vdtp_pkg::*;

    in_item_t item;
    result_t  parse_res;
    result_t  held_res;
    logic     can_load;
    logic     take;

    assign item.data_byte  = in_ch.data_byte;
    assign item.first_flag = in_ch.first_flag;
    assign item.last_flag  = in_ch.last_flag;

    // Accept whenever the result register can take the new result
    assign in_ch.ready = can_load;
    assign take        = in_ch.valid && can_load;

    // Header, record walk and limit commit; state advances on each transfer
    vdtp_parser #(
        .MAX_DESC_BYTES (MAX_DESC_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (parse_res)
    );

    // Hold the result until the sink takes it
    vdtp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .result_in  (parse_res),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .can_load   (can_load),
        .result_out (held_res)
    );

    assign out_ch.done_res      = held_res.done_res;
    assign out_ch.status        = held_res.status;
    assign out_ch.limit_updated = held_res.limit_updated;
    assign out_ch.pixel_limit   = held_res.pixel_limit;

endmodule

>>> design/vdtp_checker.sv
// Checker: port-level properties of the parser core, bound to the top level.
`timescale 1ns / 1ps

module vdtp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last_flag,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_done_res,
    input logic [1:0]  out_status,
    input logic        out_limit_updated,
    input logic [31:0] out_pixel_limit
);
    import vdtp_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel_limit))
        else $error("stalled result changed");

    // Every accepted byte shows up as a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid && out_done_res == $past(in_last_flag))
        else $error("accepted byte produced no matching result");

    // A finished descriptor always carries a final status, an unfinished one never
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_done_res == (out_status != STATUS_BUSY))
        else $error("status disagrees with done");

    // Limit replaced only on an accepted descriptor
    a_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_limit_updated |-> out_done_res && out_status == STATUS_OK)
        else $error("limit updated without accepted header");

endmodule

bind vendor_descriptor_tlv_parser_core vdtp_checker u_vdtp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_last_flag      (in_ch.last_flag),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_done_res      (out_ch.done_res),
    .out_status        (out_ch.status),
    .out_limit_updated (out_ch.limit_updated),
    .out_pixel_limit   (out_ch.pixel_limit)
);

>>> sim/vendor_descriptor_tlv_parser_core_test.sv
// Testbench: randomized byte-stream regression of the vendor descriptor TLV parser core.
`timescale 1ns / 1ps

// Drives descriptors into the parser one byte per transfer and checks every result
// against an in-bench predictor. The stimulus has three parts:
//   - directed descriptors: limit capture at the value extremes, too short, bad
//     header, early end inside a limit record, partial capture, overlapping limit
//     records, first flag mid-descriptor, a start without first flag;
//   - random descriptors, mostly well-formed with random records and content,
//     some with a broken header, a missing last flag or pure noise;
//   - an oversize descriptor four bytes past the byte limit, sent as one long
//     stretch with no idling on either side.
// Both channel sides idle at random elsewhere. The result side holds off once
// for a long stretch while bytes keep coming, and the byte side pauses until
// every expected result has been drained.
module vendor_descriptor_tlv_parser_core_test;

    import vdtp_pkg::*;

    localparam int MAX_BYTES    = 256;
    localparam int RANDOM_BYTES = 100;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [7:0] byte_q_t[$];

    // Predictor of the parser plus the queue of results it still owes.
    class descriptor_scoreboard;
        logic [8:0]  desc_len;
        logic [7:0]  hdr_lead;
        logic [7:0]  hdr_tail;
        logic        hdr_mid_good;
        phase_t      walk_phase;
        logic [7:0]  key_lo;
        logic [7:0]  skip_cnt;
        logic [2:0]  cap_left;
        logic        cap_await_len;
        logic [31:0] cap_word;
        logic        cap_armed;
        logic [31:0] limit_reg;
        result_t     owed_results[$];
        int          fails;

        function new();
            restart_descriptor();
            limit_reg = '0;
            fails     = 0;
        endfunction

        function void restart_descriptor();
            desc_len      = '0;
            hdr_lead      = '0;
            hdr_tail      = '0;
            hdr_mid_good  = 1'b0;
            walk_phase    = PH_KEY_LO;
            key_lo        = '0;
            skip_cnt      = '0;
            cap_left      = '0;
            cap_await_len = 1'b0;
            cap_word      = '0;
            cap_armed     = 1'b0;
        endfunction

        // Advance the predictor by one accepted byte and queue the result it causes.
        function void note_byte(in_item_t item);
            result_t    r;
            logic [7:0] b;
            logic [7:0] len8;
            b = item.data_byte;
            if (item.first_flag)
                restart_descriptor();
            if (desc_len < MAX_BYTES)
            begin
                case (desc_len)
                    9'd0:
                    begin
                        hdr_lead     = b;
                        hdr_mid_good = 1'b1;
                    end
                    9'd1: if (b != HDR_TAG) hdr_mid_good = 1'b0;
                    9'd2: if (b != HDR_VER) hdr_mid_good = 1'b0;
                    9'd3: if (b != HDR_PAD) hdr_mid_good = 1'b0;
                    9'd4: hdr_tail = b;
                    default:
                    begin
                        // capture sees the state before this byte's record step
                        if (!cap_await_len && cap_left != 0 && cap_left <= CAP_BYTES)
                        begin
                            cap_word = cap_word | ({24'd0, b} << (8 * (CAP_BYTES - cap_left)));
                            cap_left--;
                        end
                        case (walk_phase)
                            PH_KEY_LO:
                            begin
                                key_lo     = b;
                                walk_phase = PH_KEY_HI;
                            end
                            PH_KEY_HI:
                            begin
                                if (key_lo == KEY_LIMIT[7:0] && b == KEY_LIMIT[15:8])
                                begin
                                    cap_armed     = 1'b1;
                                    cap_word      = '0;
                                    cap_left      = CAP_BYTES;
                                    cap_await_len = 1'b1;
                                end
                                walk_phase = PH_LEN;
                            end
                            PH_LEN:
                            begin
                                cap_await_len = 1'b0;
                                skip_cnt      = b;
                                walk_phase    = (b == 8'd0) ? PH_KEY_LO : PH_SKIP;
                            end
                            default:
                            begin
                                skip_cnt--;
                                if (skip_cnt == 8'd0)
                                    walk_phase = PH_KEY_LO;
                            end
                        endcase
                    end
                endcase
                desc_len++;
            end

            r.done_res      = item.last_flag;
            r.status        = STATUS_BUSY;
            r.limit_updated = 1'b0;
            if (item.last_flag)
            begin
                len8 = desc_len[7:0];
                if (len8 <= HDR_BYTES)
                    r.status = STATUS_SHORT;
                else if (hdr_lead != len8 || !hdr_mid_good || hdr_tail != len8 - HDR_BIAS)
                    r.status = STATUS_BAD_HDR;
                else
                begin
                    r.status = STATUS_OK;
                    if (cap_armed)
                    begin
                        limit_reg       = cap_word;
                        r.limit_updated = 1'b1;
                    end
                end
                restart_descriptor();
            end
            r.pixel_limit = limit_reg;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                fails++;
            end
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual 0x%0h", $time, got);
                fails++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("limit_updated", 32'(want.limit_updated), 32'(got.limit_updated));
            compare_field("pixel_limit", want.pixel_limit, got.pixel_limit);
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vdtp_in_if  in_ch();
    vdtp_out_if out_ch();

    descriptor_scoreboard sb = new();

    // Idle controls shared by the byte sender and the result sink.
    bit src_gaps_on   = 1'b1;
    bit snk_gaps_on   = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int bytes_driven  = 0;

    vendor_descriptor_tlv_parser_core #(
        .MAX_DESC_BYTES (MAX_BYTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    // Result sink: serve a pending long hold-off first, else drop ready at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= !(snk_gaps_on && $urandom_range(99) < 8);
    end

    // Note the accepted byte before checking the result of the same edge, so a
    // result can never overtake its own prediction.
    always @(posedge clk)
    begin : transfer_monitor
        in_item_t taken;
        result_t  seen;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            taken.data_byte  = in_ch.data_byte;
            taken.first_flag = in_ch.first_flag;
            taken.last_flag  = in_ch.last_flag;
            sb.note_byte(taken);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.done_res      = out_ch.done_res;
            seen.status        = status_t'(out_ch.status);
            seen.limit_updated = out_ch.limit_updated;
            seen.pixel_limit   = out_ch.pixel_limit;
            sb.check_result(seen);
        end
    end

    // End the run when neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until the
    // transfer; valid stays high on return so back-to-back bytes leave no gap.
    task automatic put_byte(input logic [7:0] b, input logic first, input logic last);
        while (src_gaps_on && $urandom_range(99) < 8)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_flag <= first;
        in_ch.last_flag  <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_driven++;
    endtask

    task automatic send_descriptor(input byte_q_t q, input bit lead_first, input bit end_last);
        for (int i = 0; i < q.size(); i++)
            put_byte(q[i], lead_first && i == 0, end_last && i == q.size() - 1);
    endtask

    // Drop valid and wait until every owed result has come back. The first edge
    // lets the monitor note the byte of the last transfer.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Twelve-byte descriptor with a valid header and one limit record.
    task automatic make_limit_desc(input logic [31:0] v, output byte_q_t q);
        q = {8'd12, HDR_TAG, HDR_VER, HDR_PAD, 8'd10, KEY_LIMIT[7:0], KEY_LIMIT[15:8],
             8'(CAP_BYTES), v[7:0], v[15:8], v[23:16], v[31:24]};
    endtask

    // Descriptor of n bytes with a consistent header and random records, cut at
    // n so the last record may end early; optionally spoil one header byte.
    task automatic make_descriptor(input int n, input bit spoil, output byte_q_t q);
        logic [7:0] len;
        int         pos;
        q = {8'(n), HDR_TAG, HDR_VER, HDR_PAD, 8'(n - 2)};
        if (spoil)
        begin
            pos    = $urandom_range(4);
            q[pos] = q[pos] ^ 8'($urandom_range(1, 255));
        end
        while (q.size() < n)
        begin
            if ($urandom_range(99) < 45)
            begin
                len = ($urandom_range(9) < 7) ? 8'(CAP_BYTES) : 8'($urandom_range(8));
                q.push_back(KEY_LIMIT[7:0]);
                q.push_back(KEY_LIMIT[15:8]);
            end
            else
            begin
                len = 8'($urandom_range(6));
                q.push_back(8'($urandom));
                q.push_back(8'($urandom));
            end
            q.push_back(len);
            for (int i = 0; i < len; i++)
                q.push_back(8'($urandom));
        end
        while (q.size() > n)
            void'(q.pop_back());
    endtask

    // Random bytes with a stray first flag now and then, last flag at the end.
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            put_byte(8'($urandom), $urandom_range(9) == 0, i == n - 1);
    endtask

    initial
    begin : stimulus
        byte_q_t q;
        int      desc_idx;
        int      start_bytes;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.first_flag = 1'b0;
        in_ch.last_flag  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start without a first flag, then limit values at the extremes.
        make_limit_desc(32'h1234_5678, q);
        send_descriptor(q, 1'b0, 1'b1);
        make_limit_desc(32'hffff_ffff, q);
        send_descriptor(q, 1'b1, 1'b1);
        make_limit_desc(32'h0000_0000, q);
        send_descriptor(q, 1'b1, 1'b1);

        // Too short: a header-only descriptor and a single byte flagged first and last.
        send_descriptor({8'd5, HDR_TAG, HDR_VER, HDR_PAD, 8'd3}, 1'b1, 1'b1);
        send_descriptor({8'hff}, 1'b1, 1'b1);

        // Bad header: wrong tag byte, so the limit record must not commit.
        make_limit_desc(32'h0bad_0bad, q);
        q[1] = HDR_TAG ^ 8'h01;
        send_descriptor(q, 1'b1, 1'b1);

        // Early end right after the limit key: the limit becomes zero.
        make_limit_desc(32'hcafe_f00d, q);
        send_descriptor(q, 1'b1, 1'b1);
        send_descriptor({8'd7, HDR_TAG, HDR_VER, HDR_PAD, 8'd5,
                         KEY_LIMIT[7:0], KEY_LIMIT[15:8]}, 1'b1, 1'b1);

        // Partial capture: two of four value bytes arrive, upper bytes read zero.
        send_descriptor({8'd10, HDR_TAG, HDR_VER, HDR_PAD, 8'd8,
                         KEY_LIMIT[7:0], KEY_LIMIT[15:8], 8'd8, 8'haa, 8'hbb}, 1'b1, 1'b1);

        // Overlapping captures: the second restarts, but the header length is wrong.
        send_descriptor({8'd16, HDR_TAG, HDR_VER, HDR_PAD, 8'd14,
                         KEY_LIMIT[7:0], KEY_LIMIT[15:8], 8'd2, 8'h11, 8'h22,
                         KEY_LIMIT[7:0], KEY_LIMIT[15:8], 8'd4,
                         8'h33, 8'h44, 8'h55, 8'h66}, 1'b1, 1'b1);

        // First flag mid-descriptor: abandon the partial one silently.
        make_limit_desc(32'hdead_beef, q);
        q = q[0:5];
        send_descriptor(q, 1'b1, 1'b0);
        make_limit_desc(32'h8000_0001, q);
        send_descriptor(q, 1'b1, 1'b1);
        wait_for_results();

        // Random part: mostly well-formed descriptors with random records.
        desc_idx    = 0;
        start_bytes = bytes_driven;
        while (bytes_driven - start_bytes < RANDOM_BYTES)
        begin
            // Hold the result side off for a long stretch while bytes keep coming.
            if (desc_idx == 1)
                hold_requests++;
            // Pause the sender until every owed result has arrived.
            if (desc_idx == 3)
                wait_for_results();

            if ($urandom_range(99) < 70)
            begin
                make_descriptor(($urandom_range(9) == 0) ? $urandom_range(41, 120)
                                                         : $urandom_range(6, 40),
                                $urandom_range(9) == 0, q);
                send_descriptor(q, $urandom_range(9) != 0, $urandom_range(19) != 0);
            end
            else
                send_noise($urandom_range(1, 20));
            desc_idx++;
        end

        // Oversize: four bytes past the byte limit, whose extra bytes must be ignored,
        // sent as one long stretch with no idling on either side.
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        make_descriptor(MAX_BYTES + 4, 1'b0, q);
        send_descriptor(q, 1'b1, 1'b1);
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;

        // Drain everything, then keep watching for stray results.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
design/vdtp_pkg.sv
design/vdtp_in_if.sv
design/vdtp_out_if.sv
design/vdtp_parser.sv
design/vdtp_out_stage.sv
design/vendor_descriptor_tlv_parser_core.sv
design/vdtp_checker.sv
sim/vendor_descriptor_tlv_parser_core_test.sv
